// ----- rtl/i2c_eeprom_byte_access_master_defines.svh -----
// Assertion macros shared by the I2C EEPROM byte access master RTL.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_DEFINES_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_DEFINES_SVH

// same-cycle implication
`define IEBA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ieba assertion failed");

// next-cycle implication
`define IEBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ieba assertion failed");

`endif

// ----- rtl/ieba_pkg.sv -----
// Package for the I2C EEPROM byte access master: config and result structs,
// register indexes and request codes. No dependencies.
package ieba_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_WIDE_ADDRESS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_WRITE_BYTE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_WAIT_TICKS  = 3'd4;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	typedef struct packed {
		logic        wide_address;
		logic [7:0]  device_write_byte;
		logic [15:0] half_period_ticks;
		logic [7:0]  ack_timeout;
		logic [23:0] write_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_error;
	} res_t;

endpackage

// ----- rtl/i2c_eeprom_byte_access_master.sv -----
// Top level of the I2C EEPROM byte access master: config registers, bus
// sequencer and result register. Depends on ieba_pkg, ieba_cfg, ieba_seq.
//
// Single-byte random read/write master for 24Cxx-type EEPROMs. Each input
// word is one tick: req_type 1 or 2 starts a read or write when idle, and
// every word advances the bus by one step, with the SCL half period set in
// ticks by half_period_ticks. Each input word yields one result word with
// the SCL/SDA levels, busy, a one-word done pulse, the last byte read and
// ack_error on a timed-out acknowledge. One word is taken per clock cycle,
// and the result is registered: the whole step of the sequencer is computed
// combinationally from the state registers and lands in the result register, and
// the input stalls only while a result word is held by result_stall.
// Configuration writes are always ready and take effect on the next word.
module i2c_eeprom_byte_access_master (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ieba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ieba_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [1:0]                      req_type,
	input  logic [15:0]                     mem_addr,
	input  logic [7:0]                      write_data,
	input  logic                            sda_in,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            scl_out,
	output logic                            sda_out,
	output logic                            sda_drive,
	output logic                            busy_res,
	output logic                            done_res,
	output logic [7:0]                      read_data,
	output logic                            ack_error
);
	import ieba_pkg::*;

	cfg_t cfg;
	res_t res_next, res_q;
	logic res_valid_q;
	logic accept;

	assign item_stall = res_valid_q & result_stall;
	assign accept     = item_valid & ~item_stall;

	ieba_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ieba_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (accept),
		.req_type   (req_type),
		.mem_addr   (mem_addr),
		.write_data (write_data),
		.sda_in     (sda_in),
		.cfg        (cfg),
		.res        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_next;
		end
	end

	assign result_valid = res_valid_q;
	assign scl_out      = res_q.scl_out;
	assign sda_out      = res_q.sda_out;
	assign sda_drive    = res_q.sda_drive;
	assign busy_res     = res_q.busy_res;
	assign done_res     = res_q.done_res;
	assign read_data    = res_q.read_data;
	assign ack_error    = res_q.ack_error;

`include "i2c_eeprom_byte_access_master_defines.svh"

	`IEBA_ASSERT_NEXT(a_accept_gives_result, accept, result_valid)
	`IEBA_ASSERT_SAME(a_done_not_busy, result_valid && done_res, !busy_res)
	`IEBA_ASSERT_SAME(a_err_with_done, result_valid && ack_error, done_res)
	`IEBA_ASSERT_SAME(a_released_high, result_valid && !sda_drive, sda_out)

endmodule

// ----- rtl/ieba_cfg.sv -----
// Configuration register file of the I2C EEPROM byte access master.
// Depends on ieba_pkg.
module ieba_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ieba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ieba_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ieba_pkg::cfg_t                   cfg
);
	import ieba_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide_address      <= 1'b0;
			cfg_q.device_write_byte <= 8'hA0;
			cfg_q.half_period_ticks <= 16'd500;
			cfg_q.ack_timeout       <= 8'd250;
			cfg_q.write_wait_ticks  <= 24'd250000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDE_ADDRESS:      cfg_q.wide_address      <= cfg_data[0];
				REG_DEVICE_WRITE_BYTE: cfg_q.device_write_byte <= cfg_data[7:0];
				REG_HALF_PERIOD_TICKS: cfg_q.half_period_ticks <= cfg_data[15:0];
				REG_ACK_TIMEOUT:       cfg_q.ack_timeout       <= cfg_data[7:0];
				REG_WRITE_WAIT_TICKS:  cfg_q.write_wait_ticks  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/ieba_seq.sv -----
// Bus sequencer of the I2C EEPROM byte access master: state registers and
// the one-tick step. Depends on ieba_pkg.
module ieba_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  logic [1:0]     req_type,
	input  logic [15:0]    mem_addr,
	input  logic [7:0]     write_data,
	input  logic           sda_in,
	input  ieba_pkg::cfg_t cfg,
	output ieba_pkg::res_t res
);
	import ieba_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE, PH_START1, PH_DEV, PH_DEV_ACK, PH_AHI, PH_AHI_ACK, PH_ALO, PH_ALO_ACK,
		PH_DATA, PH_DATA_ACK, PH_START2, PH_RDEV, PH_RDEV_ACK, PH_RX, PH_NACK,
		PH_STOP, PH_STOP_ERR, PH_WWAIT
	} phase_t;

	function automatic logic is_ack(input phase_t p);
		return p == PH_DEV_ACK || p == PH_AHI_ACK || p == PH_ALO_ACK ||
		       p == PH_DATA_ACK || p == PH_RDEV_ACK;
	endfunction

	function automatic logic is_tx(input phase_t p);
		return p == PH_DEV || p == PH_AHI || p == PH_ALO || p == PH_DATA || p == PH_RDEV;
	endfunction

	phase_t      phase_q, n_phase, tgt, ack_next, tx_next;
	logic [3:0]  bc_q, n_bc;
	logic [7:0]  shift_q, n_shift;
	logic [15:0] td_q, n_td, td_inc, hp;
	logic [7:0]  awc_q, n_awc;
	logic [15:0] held_addr_q, n_held_addr;
	logic [7:0]  held_data_q, n_held_data;
	logic        is_read_q, n_is_read;
	logic [7:0]  last_q, n_last;
	logic [23:0] wwc_q, n_wwc, wwc_dec;
	logic [7:0]  dev_b;
	logic        do_enter, do_finish, end_flag, err_flag;

	assign hp     = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
	assign td_inc = td_q + 16'd1;
	assign wwc_dec = (wwc_q != 24'd0) ? wwc_q - 24'd1 : 24'd0;
	assign dev_b  = cfg.device_write_byte +
		(cfg.wide_address ? 8'd0 : {4'd0, held_addr_q[10:8], 1'b0});

	always_comb begin
		unique case (phase_q)
			PH_DEV_ACK:  ack_next = cfg.wide_address ? PH_AHI : PH_ALO;
			PH_AHI_ACK:  ack_next = PH_ALO;
			PH_ALO_ACK:  ack_next = is_read_q ? PH_START2 : PH_DATA;
			PH_DATA_ACK: ack_next = PH_STOP;
			default:     ack_next = PH_RX;
		endcase
		unique case (phase_q)
			PH_DEV:  tx_next = PH_DEV_ACK;
			PH_AHI:  tx_next = PH_AHI_ACK;
			PH_ALO:  tx_next = PH_ALO_ACK;
			PH_DATA: tx_next = PH_DATA_ACK;
			default: tx_next = PH_RDEV_ACK;
		endcase
	end

	always_comb begin
		n_phase     = phase_q;
		n_bc        = bc_q;
		n_shift     = shift_q;
		n_td        = td_q;
		n_awc       = awc_q;
		n_held_addr = held_addr_q;
		n_held_data = held_data_q;
		n_is_read   = is_read_q;
		n_last      = last_q;
		n_wwc       = wwc_q;
		do_enter    = 1'b0;
		do_finish   = 1'b0;
		err_flag    = 1'b0;
		tgt         = PH_IDLE;

		if (phase_q == PH_IDLE) begin
			if (req_type == REQ_READ || req_type == REQ_WRITE) begin
				n_held_addr = mem_addr;
				n_held_data = write_data;
				n_is_read   = (req_type == REQ_READ);
				do_enter    = 1'b1;
				tgt         = PH_START1;
			end
		end else if (phase_q == PH_WWAIT) begin
			n_wwc = wwc_dec;
			if (wwc_dec == 24'd0)
				do_finish = 1'b1;
		end else if (is_ack(phase_q) && bc_q >= 4'd2) begin
			if (!sda_in) begin
				do_enter = 1'b1;
				tgt      = ack_next;
			end else if (awc_q >= cfg.ack_timeout) begin
				do_enter = 1'b1;
				tgt      = PH_STOP_ERR;
			end else begin
				n_awc = awc_q + 8'd1;
			end
		end else if (td_inc < hp) begin
			n_td = td_inc;
		end else begin
			n_td = 16'd0;
			priority if (phase_q == PH_START1 || phase_q == PH_START2) begin
				if (bc_q < 4'd2) begin
					n_bc = bc_q + 4'd1;
				end else begin
					do_enter = 1'b1;
					tgt      = (phase_q == PH_START1) ? PH_DEV : PH_RDEV;
				end
			end else if (is_tx(phase_q)) begin
				if (bc_q[0])
					n_shift = {shift_q[6:0], 1'b0};
				if (bc_q == 4'd15) begin
					do_enter = 1'b1;
					tgt      = tx_next;
				end else begin
					n_bc = bc_q + 4'd1;
				end
			end else if (is_ack(phase_q)) begin
				n_bc = bc_q + 4'd1;
			end else if (phase_q == PH_RX) begin
				if (bc_q[0])
					n_shift = {shift_q[6:0], sda_in};
				if (bc_q == 4'd15) begin
					n_last   = n_shift;
					do_enter = 1'b1;
					tgt      = PH_NACK;
				end else begin
					n_bc = bc_q + 4'd1;
				end
			end else if (phase_q == PH_NACK) begin
				if (bc_q < 4'd1) begin
					n_bc = bc_q + 4'd1;
				end else begin
					do_enter = 1'b1;
					tgt      = PH_STOP;
				end
			end else if (phase_q == PH_STOP || phase_q == PH_STOP_ERR) begin
				if (bc_q < 4'd2) begin
					n_bc = bc_q + 4'd1;
				end else if (phase_q == PH_STOP_ERR) begin
					do_finish = 1'b1;
					err_flag  = 1'b1;
				end else if (is_read_q || cfg.write_wait_ticks == 24'd0) begin
					do_finish = 1'b1;
				end else begin
					do_enter = 1'b1;
					tgt      = PH_WWAIT;
					n_wwc    = cfg.write_wait_ticks;
				end
			end else begin
				do_finish = 1'b1;
			end
		end

		if (do_enter) begin
			n_phase = tgt;
			n_bc    = 4'd0;
			n_td    = 16'd0;
			unique case (tgt)
				PH_DEV:  n_shift = dev_b;
				PH_AHI:  n_shift = held_addr_q[15:8];
				PH_ALO:  n_shift = held_addr_q[7:0];
				PH_DATA: n_shift = held_data_q;
				PH_RDEV: n_shift = dev_b + 8'd1;
				PH_RX:   n_shift = 8'd0;
				default: ;
			endcase
			if (is_ack(tgt))
				n_awc = 8'd0;
		end
		if (do_finish) begin
			n_phase = PH_IDLE;
			n_bc    = 4'd0;
			n_td    = 16'd0;
		end
		end_flag = do_finish;
	end

	// bus levels after this tick
	always_comb begin
		res.scl_out   = 1'b1;
		res.sda_out   = 1'b1;
		res.sda_drive = 1'b0;
		unique case (n_phase)
			PH_START1, PH_START2: begin
				res.scl_out   = (n_bc != 4'd0);
				res.sda_out   = (n_bc < 4'd2);
				res.sda_drive = 1'b1;
			end
			PH_DEV, PH_AHI, PH_ALO, PH_DATA, PH_RDEV: begin
				res.scl_out   = n_bc[0];
				res.sda_out   = n_shift[7];
				res.sda_drive = 1'b1;
			end
			PH_DEV_ACK, PH_AHI_ACK, PH_ALO_ACK, PH_DATA_ACK, PH_RDEV_ACK: begin
				res.scl_out = (n_bc != 4'd0);
			end
			PH_RX: begin
				res.scl_out = n_bc[0];
			end
			PH_NACK: begin
				res.scl_out   = n_bc[0];
				res.sda_drive = 1'b1;
			end
			PH_STOP, PH_STOP_ERR: begin
				res.scl_out   = (n_bc != 4'd0);
				res.sda_out   = (n_bc >= 4'd2);
				res.sda_drive = 1'b1;
			end
			default: ;
		endcase
		res.busy_res  = (n_phase != PH_IDLE);
		res.done_res  = end_flag;
		res.read_data = n_last;
		res.ack_error = end_flag & err_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bc_q        <= 4'd0;
			shift_q     <= 8'd0;
			td_q        <= 16'd0;
			awc_q       <= 8'd0;
			held_addr_q <= 16'd0;
			held_data_q <= 8'd0;
			is_read_q   <= 1'b0;
			last_q      <= 8'd0;
			wwc_q       <= 24'd0;
		end else if (step_en) begin
			phase_q     <= n_phase;
			bc_q        <= n_bc;
			shift_q     <= n_shift;
			td_q        <= n_td;
			awc_q       <= n_awc;
			held_addr_q <= n_held_addr;
			held_data_q <= n_held_data;
			is_read_q   <= n_is_read;
			last_q      <= n_last;
			wwc_q       <= n_wwc;
		end
	end

endmodule
